// ===== rtl/core/tce_pkg.sv =====
package tce_pkg;

    // Adjacency row width, fixed by the row format.
    localparam int ROW_W = 32;

    // Width of the node count register and its value after reset.
    localparam int NODE_CNT_W = 6;
    localparam int NODE_RESET = 32;

    // Default row capacity of the matrix store.
    localparam int DEF_MAX_NODES = 32;

endpackage

// ===== rtl/core/tce_ram.sv =====
module tce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/transitive_closure_engine.sv =====
// Warshall transitive closure over a boolean adjacency matrix of up to
// min(MAX_NODES, 32) nodes. Load the matrix one row per beat (start high while
// busy is low); a beat takes one cycle. The beat flagged i_last_row starts the
// closure, and busy stays high until the closed rows have been sent. The
// closure runs n passes (n = active node count) through the row store; each
// pass spends one cycle reading the pivot row and then one cycle per row,
// since the single read port of the row store handles one row a cycle, so a
// closure takes n*(n+1) cycles. The n result rows then follow at one per
// cycle, each shown for a single cycle with o_strobe high and the final one
// marked by o_last_out: the receiver cannot stall, so capture every strobed
// beat. The last-row beat to its final result spans n*(n+2)+1 cycles, and
// busy drops in the cycle that shows the final row, so the next matrix may
// start loading right then. Bits at or above n are cleared, missing rows read
// as zero, and rows beyond n are dropped. Write i_cfg_data (node count, 0
// taken as 1, large values capped) only while the block is idle.
module transitive_closure_engine
    import tce_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ROW_W-1:0]      i_row_bits,
    input  logic                  i_last_row,
    output logic                  o_strobe,
    output logic [ROW_W-1:0]      o_closure_bits,
    output logic                  o_last_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [NODE_CNT_W-1:0] i_cfg_data
);

    localparam int NODE_CAP = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
    localparam int IDX_W    = $clog2(NODE_CAP);
    localparam int CNT_W    = $clog2(NODE_CAP + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PIVOT = 4'b0010,
        ST_PASS  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    // What the row store returns in the cycle after a read.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_PIVOT,
        RD_ROW,
        RD_EMIT
    } t_rd_kind;

    t_state               r_state, n_state;
    logic [NODE_CNT_W-1:0] r_node_cfg;
    logic [CNT_W-1:0]     r_rows, n_rows;
    logic [NODE_CAP-1:0]  r_valid, n_valid;
    logic [IDX_W-1:0]     r_k, n_k;
    logic [IDX_W-1:0]     r_i, n_i;
    logic [IDX_W-1:0]     r_n_last, n_n_last;
    logic [ROW_W-1:0]     r_mask, n_mask;
    logic [ROW_W-1:0]     r_pivot;
    logic [IDX_W-1:0]     r_pivot_k;
    t_rd_kind             r_p1_kind, n_p1_kind;
    logic [IDX_W-1:0]     r_p1_addr;
    logic                 r_p1_last, n_p1_last;
    logic                 r_p1_vld;
    logic                 r_fwd_hit;
    logic [ROW_W-1:0]     r_fwd_data;

    logic [CNT_W-1:0]     w_n;
    logic [ROW_W-1:0]     w_mask;
    logic                 w_accept;
    logic                 w_load_we;
    logic                 w_upd;
    logic [ROW_W-1:0]     w_rd_raw;
    logic [ROW_W-1:0]     w_row;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [ROW_W-1:0]     w_wdata;
    logic                 w_re;
    logic [IDX_W-1:0]     w_raddr;
    logic                 w_hit;
    logic [ROW_W-1:0]     w_ram_q;

    // Clamp the node count: zero acts as one, large values cap at capacity.
    always_comb begin
        if (r_node_cfg == '0) begin
            w_n = CNT_W'(1);
        end else if (r_node_cfg > NODE_CNT_W'(NODE_CAP)) begin
            w_n = CNT_W'(NODE_CAP);
        end else begin
            w_n = CNT_W'(r_node_cfg);
        end
    end

    assign w_mask    = ~({ROW_W{1'b1}} << w_n);
    assign w_accept  = start && !busy;
    assign w_load_we = w_accept && (r_rows < w_n);

    // Read data as the closure sees it: forwarded when the row was written in
    // the read cycle, zero for a row never loaded, and masked to n columns.
    assign w_rd_raw = r_fwd_hit ? r_fwd_data : w_ram_q;
    assign w_row    = r_p1_vld ? (w_rd_raw & r_mask) : '0;

    // Row update: a row that reaches the pivot takes in the pivot row.
    assign w_upd   = (r_p1_kind == RD_ROW) && w_row[r_pivot_k];
    assign w_we    = w_load_we || w_upd;
    assign w_waddr = w_upd ? r_p1_addr : r_rows[IDX_W-1:0];
    assign w_wdata = w_upd ? (w_row | r_pivot) : (i_row_bits & w_mask);

    always_comb begin
        n_state   = r_state;
        n_rows    = r_rows;
        n_valid   = r_valid;
        n_k       = r_k;
        n_i       = r_i;
        n_n_last  = r_n_last;
        n_mask    = r_mask;
        n_p1_kind = RD_NONE;
        n_p1_last = 1'b0;
        w_re      = 1'b0;
        w_raddr   = r_i;

        if (w_load_we) begin
            n_valid[r_rows[IDX_W-1:0]] = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_rows != CNT_W'(NODE_CAP)) begin
                        n_rows = r_rows + CNT_W'(1);
                    end
                    if (i_last_row) begin
                        // Latch the count in force now; it governs the closure.
                        n_rows   = '0;
                        n_n_last = IDX_W'(w_n - CNT_W'(1));
                        n_mask   = w_mask;
                        n_k      = '0;
                        n_state  = ST_PIVOT;
                    end
                end
            end
            ST_PIVOT: begin
                w_re      = 1'b1;
                w_raddr   = r_k;
                n_p1_kind = RD_PIVOT;
                n_i       = '0;
                n_state   = ST_PASS;
            end
            ST_PASS: begin
                w_re      = 1'b1;
                w_raddr   = r_i;
                n_p1_kind = RD_ROW;
                if (r_i == r_n_last) begin
                    n_i = '0;
                    if (r_k == r_n_last) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = ST_PIVOT;
                    end
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                w_re      = 1'b1;
                w_raddr   = r_i;
                n_p1_kind = RD_EMIT;
                n_p1_last = (r_i == r_n_last);
                if (r_i == r_n_last) begin
                    // Drop the matrix; the last row was already sampled.
                    n_valid = '0;
                    n_i     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_hit = w_we && w_re && (w_waddr == w_raddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_node_cfg <= NODE_CNT_W'(NODE_RESET);
            r_rows     <= '0;
            r_valid    <= '0;
            r_k        <= '0;
            r_i        <= '0;
            r_p1_kind  <= RD_NONE;
            r_p1_last  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rows    <= n_rows;
            r_valid   <= n_valid;
            r_k       <= n_k;
            r_i       <= n_i;
            r_p1_kind <= n_p1_kind;
            r_p1_last <= n_p1_last;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_cfg <= i_cfg_data;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_n_last   <= n_n_last;
        r_mask     <= n_mask;
        r_p1_addr  <= w_raddr;
        r_p1_vld   <= r_valid[w_raddr] || w_hit;
        r_fwd_hit  <= w_hit;
        r_fwd_data <= w_wdata;
        if (r_p1_kind == RD_PIVOT) begin
            r_pivot   <= w_row;
            r_pivot_k <= r_p1_addr;
        end
    end

    tce_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_CAP)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_strobe       = (r_p1_kind == RD_EMIT);
    assign o_closure_bits = w_row;
    assign o_last_out     = r_p1_last;

endmodule

// ===== rtl/core/tce_checker.sv =====
module tce_checker
    import tce_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  i_last_row,
    input logic                  o_strobe,
    input logic                  o_last_out
);

    // A last-row beat starts the closure.
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_row) |=> busy)
        else $error("closure did not start after last row");

    // Other beats only load a row.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_row) |=> !busy)
        else $error("busy after a plain row beat");

    // Results appear only right after a busy cycle.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without preceding closure");

    // The final row is a strobed beat and ends the burst.
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |-> (o_strobe && !busy) ##1 !o_strobe)
        else $error("final row marker misplaced");

endmodule

bind transitive_closure_engine tce_checker u_tce_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_last_row (i_last_row),
    .o_strobe   (o_strobe),
    .o_last_out (o_last_out)
);
